@@ rtl/key_value_table_unit_assert.svh @@
// assertion macros used by the table datapath
`ifndef KEY_VALUE_TABLE_UNIT_ASSERT_SVH
`define KEY_VALUE_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define KVT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kvt same-cycle check failed");

// next-cycle implication, checked on every rising clock edge out of reset
`define KVT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kvt next-cycle check failed");

`endif

@@ rtl/kvt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package kvt_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    // command codes
    localparam logic [2:0] CMD_PUT      = 3'd0;
    localparam logic [2:0] CMD_GET      = 3'd1;
    localparam logic [2:0] CMD_REMOVE   = 3'd2;
    localparam logic [2:0] CMD_CONTAINS = 3'd3;
    localparam logic [2:0] CMD_CLEAR    = 3'd4;

    // result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_EMPTY   = 2'd2;
    localparam logic [1:0] STAT_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] lookup_key;
        logic [31:0] new_value;
    } kvt_cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_value;
        logic        key_present;
        logic [4:0]  entry_count;
    } kvt_rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } kvt_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } kvt_ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } kvt_stat_t;

endpackage

`default_nettype wire

@@ rtl/kvt_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "key_value_table_unit_assert.svh"

module kvt_datapath
    import kvt_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire kvt_ctrl_t ctrl,
    output kvt_stat_t      stat,
    input  wire kvt_cmd_t  cmd_data,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output kvt_rsp_t       rsp_data
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    logic [KEY_BITS-1:0]   key_mem [CAPACITY];
    logic [VALUE_BITS-1:0] val_mem [CAPACITY];

    // captured transaction
    logic [2:0]            cmd_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;

    // scan pipeline
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic                  rd_live_reg;
    logic [ADDR_W-1:0]     rd_idx_reg;
    logic                  vld_rd_reg;
    logic [KEY_BITS-1:0]   key_rd_reg;
    logic [VALUE_BITS-1:0] val_rd_reg;
    logic                  match;

    logic                  hit_reg, hit_next;
    logic [ADDR_W-1:0]     hit_idx_reg, hit_idx_next;
    logic [VALUE_BITS-1:0] hit_val_reg, hit_val_next;
    logic                  free_reg, free_next;
    logic [ADDR_W-1:0]     free_idx_reg, free_idx_next;

    // table state
    logic [CAPACITY-1:0]   valid_reg, valid_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    logic                  rsp_valid_reg, rsp_valid_next;
    kvt_rsp_t              rsp_reg, rsp_next;

    logic                  wr_key_en, wr_val_en;
    logic [ADDR_W-1:0]     wr_addr;

    // first hit and first free slot as the reads come back
    always_comb
    begin
        match         = rd_live_reg && vld_rd_reg && (key_rd_reg == key_reg);
        addr_next     = addr_reg;
        hit_next      = hit_reg || match;
        hit_idx_next  = hit_idx_reg;
        hit_val_next  = hit_val_reg;
        free_next     = free_reg || (rd_live_reg && !vld_rd_reg);
        free_idx_next = free_idx_reg;
        if (match && !hit_reg)
        begin
            hit_idx_next = rd_idx_reg;
            hit_val_next = val_rd_reg;
        end
        if (rd_live_reg && !vld_rd_reg && !free_reg)
        begin
            free_idx_next = rd_idx_reg;
        end
        if (ctrl.scan)
        begin
            addr_next = addr_reg + ADDR_W'(1);
        end
        if (ctrl.load)
        begin
            addr_next = '0;
            hit_next  = 1'b0;
            free_next = 1'b0;
        end
    end

    // table update and result
    always_comb
    begin
        valid_next           = valid_reg;
        count_next           = count_reg;
        wr_key_en            = 1'b0;
        wr_val_en            = 1'b0;
        wr_addr              = hit_reg ? hit_idx_reg : free_idx_reg;
        rsp_next             = rsp_reg;
        rsp_valid_next       = rsp_valid_reg && rsp_stall;
        if (ctrl.commit)
        begin
            rsp_next.status      = STAT_OK;
            rsp_next.found_value = '0;
            rsp_next.key_present = 1'b0;
            case (cmd_reg)
                CMD_PUT:
                begin
                    if (hit_reg)
                    begin
                        wr_val_en            = 1'b1;
                        rsp_next.key_present = 1'b1;
                    end
                    else if (free_reg)
                    begin
                        wr_key_en               = 1'b1;
                        wr_val_en               = 1'b1;
                        valid_next[free_idx_reg] = 1'b1;
                        count_next              = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        rsp_next.status = STAT_FULL;
                    end
                end
                CMD_GET, CMD_REMOVE:
                begin
                    if (count_reg == '0)
                    begin
                        rsp_next.status = STAT_EMPTY;
                    end
                    else if (!hit_reg)
                    begin
                        rsp_next.status = STAT_UNKNOWN;
                    end
                    else
                    begin
                        rsp_next.found_value = 32'(hit_val_reg);
                        rsp_next.key_present = 1'b1;
                        if (cmd_reg == CMD_REMOVE)
                        begin
                            valid_next[hit_idx_reg] = 1'b0;
                            count_next              = count_reg - CNT_W'(1);
                        end
                    end
                end
                CMD_CONTAINS:
                begin
                    rsp_next.key_present = hit_reg;
                end
                CMD_CLEAR:
                begin
                    valid_next = '0;
                    count_next = '0;
                end
                default:
                begin
                end
            endcase
            rsp_next.entry_count = 5'(count_next);
            rsp_valid_next       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            rd_live_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            valid_reg     <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            addr_reg      <= addr_next;
            rd_live_reg   <= ctrl.scan;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= cmd_data.command;
            key_reg <= KEY_BITS'(cmd_data.lookup_key);
            val_reg <= VALUE_BITS'(cmd_data.new_value);
        end
        rd_idx_reg   <= addr_reg;
        vld_rd_reg   <= valid_reg[addr_reg];
        hit_idx_reg  <= hit_idx_next;
        hit_val_reg  <= hit_val_next;
        free_idx_reg <= free_idx_next;
        rsp_reg      <= rsp_next;
    end

    // key and value memories
    always_ff @(posedge clk)
    begin
        if (wr_key_en)
        begin
            key_mem[wr_addr] <= key_reg;
        end
        if (wr_val_en)
        begin
            val_mem[wr_addr] <= val_reg;
        end
        key_rd_reg <= key_mem[addr_reg];
        val_rd_reg <= val_mem[addr_reg];
    end

    assign stat.scan_last = (addr_reg == ADDR_W'(CAPACITY - 1));
    assign stat.out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid      = rsp_valid_reg;
    assign rsp_data       = rsp_reg;

    `KVT_ASSERT_NOW(a_count_matches_valid, 1'b1, $countones(valid_reg) == int'(count_reg))
    `KVT_ASSERT_NOW(a_commit_when_free, ctrl.commit, !rsp_valid_reg || !rsp_stall)
    `KVT_ASSERT_NEXT(a_commit_gives_result, ctrl.commit, rsp_valid_reg)

endmodule

`default_nettype wire

@@ rtl/kvt_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kvt_controller
    import kvt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_valid,
    input  wire logic [2:0] command,
    output logic            cmd_stall,
    input  wire kvt_stat_t  stat,
    output kvt_ctrl_t       ctrl
);

    kvt_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        cmd_stall  = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                cmd_stall = 1'b0;
                if (cmd_valid)
                begin
                    ctrl.load  = 1'b1;
                    // clear needs no search
                    state_next = (command == CMD_CLEAR) ? S_COMMIT : S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctrl.scan = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (stat.out_free)
                begin
                    ctrl.commit = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/key_value_table_unit.sv @@
// key/value table with unique keys and a linear search over all slots
// command channel: cmd_valid / cmd_stall / cmd_data carry put, get, remove,
//   contains or clear; a transaction completes when valid is high and stall low
// response channel: rsp_valid / rsp_stall / rsp_data return one result per
//   command: status, found value, key-present flag and entry count
// search: a command reads every slot of the key and value memories in turn,
//   one read per slot through the single shared read port, then drains the
//   read pipeline and commits the result to the output register
// a new command is taken only once the current one has committed, so commands
//   do not overlap; clear skips the slot scan and goes straight to commit
// the result sits in an output register, so the next command is taken while
//   a finished result still waits on the response side
// if the receiver stalls, the response holds steady and a later command
//   waits at commit until the output register frees up
// reset clears the slot valid bits, the entry count and the control state;
//   key and value memories are not cleared and are only read behind a valid bit
`timescale 1ns / 1ps
`default_nettype none

module key_value_table_unit
    import kvt_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cmd_valid,
    output logic          cmd_stall,
    input  wire kvt_cmd_t cmd_data,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output kvt_rsp_t      rsp_data
);

    // command and status between sequencer and datapath
    kvt_ctrl_t ctrl;
    kvt_stat_t stat;

    // sequencer: idle, scan all slots, drain, commit
    kvt_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .command   (cmd_data.command),
        .cmd_stall (cmd_stall),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // slot memories, valid bits, search pipeline and result register
    kvt_datapath #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .cmd_data  (cmd_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import kvt_pkg::*;

    // table geometry taken from the package defaults
    localparam int TABLE_SLOTS = CAPACITY_DEF;

    // command codes the block leaves unused
    localparam logic [2:0] CMD_RESERVED_LO = 3'd5;
    localparam logic [2:0] CMD_RESERVED_HI = 3'd7;

    // keys the well-formed traffic draws from: more keys than slots, so full
    // and unknown-key answers both show up
    localparam int KEY_POOL_SIZE = 24;

    // settle time after the last result
    localparam int SETTLE_CYCLES = 2 * (TABLE_SLOTS + 3);

    // slowest run is roughly 900 transactions, each a full search plus long gaps and long stalls
    localparam int CYCLE_LIMIT = 200000;

    localparam int RANDOM_PER_PHASE = 300;

    // one row of the directed table; expectation typed in only when 'typed'
    typedef struct {
        kvt_cmd_t cmd;
        bit       typed;
        kvt_rsp_t rsp;
    } directed_row_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_stall;
    kvt_cmd_t cmd_data = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    kvt_rsp_t rsp_data;

    // idle percentages for the sender and the receiver, changed per phase
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    int error_count = 0;
    int cycle_count = 0;

    // predictor copy of the table state
    bit          slot_used [TABLE_SLOTS];
    logic [31:0] slot_key  [TABLE_SLOTS];
    logic [31:0] slot_value[TABLE_SLOTS];
    logic [4:0]  stored_count;

    logic [31:0]   key_pool[KEY_POOL_SIZE];
    kvt_rsp_t      pending_responses[$];
    directed_row_t directed_rows[$];

    key_value_table_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    // 12 ns clock
    always #6 clk = ~clk;

    // run limit, counted on every rising edge
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_responses.size());
            $display("FAIL key_value_table_unit");
            $finish;
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    // one line per mismatch, plus the running count
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
    begin
        error_count++;
        $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    end
    endtask

    // response checker: every accepted transaction on the result side is
    // compared field by field with the oldest expectation
    always @(posedge clk)
    begin
        kvt_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_responses.size() == 0)
            begin
                report_mismatch("unexpected result", 64'(rsp_data), 64'd0);
            end
            else
            begin
                want = pending_responses.pop_front();
                if (rsp_data.status !== want.status)
                    report_mismatch("status", 64'(rsp_data.status), 64'(want.status));
                if (rsp_data.found_value !== want.found_value)
                    report_mismatch("found_value", 64'(rsp_data.found_value),
                                    64'(want.found_value));
                if (rsp_data.key_present !== want.key_present)
                    report_mismatch("key_present", 64'(rsp_data.key_present),
                                    64'(want.key_present));
                if (rsp_data.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 64'(rsp_data.entry_count),
                                    64'(want.entry_count));
            end
        end
    end

    // table predictor: applies one command to the local copy and returns
    // the result it should produce
    function automatic kvt_rsp_t table_model_step(input kvt_cmd_t c);
        kvt_rsp_t r;
        int       hit;
        int       hole;
        r    = '0;
        hit  = -1;
        hole = -1;
        // descending walk leaves the lowest matching and lowest free slot
        for (int i = TABLE_SLOTS - 1; i >= 0; i--)
        begin
            if (slot_used[i] && slot_key[i] == c.lookup_key)
                hit = i;
            if (!slot_used[i])
                hole = i;
        end
        r.status = STAT_OK;
        case (c.command)
            CMD_PUT:
            begin
                if (hit >= 0)
                begin
                    // replace in place
                    slot_value[hit] = c.new_value;
                    r.key_present   = 1'b1;
                end
                else if (hole < 0)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    slot_used[hole]  = 1'b1;
                    slot_key[hole]   = c.lookup_key;
                    slot_value[hole] = c.new_value;
                    stored_count++;
                end
            end
            CMD_GET, CMD_REMOVE:
            begin
                // empty takes priority over unknown key
                if (stored_count == 0)
                    r.status = STAT_EMPTY;
                else if (hit < 0)
                    r.status = STAT_UNKNOWN;
                else
                begin
                    r.found_value = slot_value[hit];
                    r.key_present = 1'b1;
                    if (c.command == CMD_REMOVE)
                    begin
                        slot_used[hit] = 1'b0;
                        stored_count--;
                    end
                end
            end
            CMD_CONTAINS:
            begin
                r.key_present = (hit >= 0);
            end
            CMD_CLEAR:
            begin
                foreach (slot_used[i])
                    slot_used[i] = 1'b0;
                stored_count = '0;
            end
            default:
            begin
                // unused codes leave everything alone
            end
        endcase
        r.entry_count = stored_count;
        return r;
    endfunction

    // drive one command, wait for its transaction, then record the expectation;
    // valid stays up between back-to-back commands
    task automatic send_command(input kvt_cmd_t c, input bit typed, input kvt_rsp_t typed_rsp);
        kvt_rsp_t predicted;
    begin
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= c;
        do
            @(posedge clk);
        while (cmd_stall);
        // predictor always runs so the table copy stays in step
        predicted = table_model_step(c);
        if (typed)
            pending_responses.push_back(typed_rsp);
        else
            pending_responses.push_back(predicted);
    end
    endtask

    // hold off the sender until every expected result is back
    task automatic wait_results_drained;
    begin
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending_responses.size() != 0)
            @(posedge clk);
    end
    endtask

    function automatic void add_row(input logic [2:0] cmd, input logic [31:0] key,
                                    input logic [31:0] val, input bit typed,
                                    input logic [1:0] st, input logic [31:0] fv,
                                    input logic kp, input logic [4:0] cnt);
        directed_row_t row;
        row.cmd.command     = cmd;
        row.cmd.lookup_key  = key;
        row.cmd.new_value   = val;
        row.typed           = typed;
        row.rsp.status      = st;
        row.rsp.found_value = fv;
        row.rsp.key_present = kp;
        row.rsp.entry_count = cnt;
        directed_rows.push_back(row);
    endfunction

    // random command shaped by the kind of burst it belongs to
    function automatic kvt_cmd_t random_command(input int kind);
        kvt_cmd_t c;
        c.lookup_key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        c.new_value  = $urandom();
        if (kind < 30)
        begin
            // fill burst: puts over the pool, runs into a full table
            c.command = CMD_PUT;
        end
        else if (kind < 55)
        begin
            // mixed traffic on pool keys, the odd clear
            c.command = ($urandom_range(0, 39) == 0) ? CMD_CLEAR
                      : 3'($urandom_range(CMD_PUT, CMD_CONTAINS));
        end
        else if (kind < 75)
        begin
            // drain burst: removes with some gets
            c.command = ($urandom_range(0, 3) == 0) ? CMD_GET : CMD_REMOVE;
        end
        else if (kind < 90)
        begin
            // lookups, half of them on keys that are almost surely absent
            c.command = $urandom_range(0, 1) ? CMD_GET : CMD_CONTAINS;
            if ($urandom_range(0, 1))
                c.lookup_key = $urandom();
        end
        else
        begin
            // noise: any code, any key
            c.command = 3'($urandom_range(CMD_PUT, CMD_RESERVED_HI));
            if ($urandom_range(0, 1))
                c.lookup_key = $urandom();
        end
        return c;
    endfunction

    // random bursts of one kind each; unused codes do not count
    task automatic run_random(input int n_items);
        int       counted;
        int       kind;
        int       burst_len;
        kvt_cmd_t c;
    begin
        counted = 0;
        while (counted < n_items)
        begin
            kind      = $urandom_range(0, 99);
            burst_len = $urandom_range(4, 24);
            for (int i = 0; i < burst_len; i++)
            begin
                c = random_command(kind);
                send_command(c, 1'b0, '0);
                if (c.command <= CMD_CLEAR)
                    counted++;
            end
        end
    end
    endtask

    initial
    begin
        // pool holds the key extremes plus random keys
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL_SIZE; i++)
            key_pool[i] = $urandom();
        foreach (slot_used[i])
            slot_used[i] = 1'b0;
        stored_count = '0;

        // directed table: empty table, extremes, replace, misses, unused codes, clear
        add_row(CMD_GET,         32'h0000_0000, 32'h0,         1, STAT_EMPTY,   32'h0,         0, 0);
        add_row(CMD_REMOVE,      32'hFFFF_FFFF, 32'h0,         1, STAT_EMPTY,   32'h0,         0, 0);
        add_row(CMD_CONTAINS,    32'h0000_0000, 32'h0,         1, STAT_OK,      32'h0,         0, 0);
        add_row(CMD_PUT,         32'h0000_0000, 32'hFFFF_FFFF, 1, STAT_OK,      32'h0,         0, 1);
        add_row(CMD_PUT,         32'hFFFF_FFFF, 32'h0000_0000, 1, STAT_OK,      32'h0,         0, 2);
        add_row(CMD_GET,         32'h0000_0000, 32'h1234_5678, 1, STAT_OK,      32'hFFFF_FFFF, 1, 2);
        add_row(CMD_GET,         32'h1234_5678, 32'h0,         1, STAT_UNKNOWN, 32'h0,         0, 2);
        add_row(CMD_PUT,         32'h0000_0000, 32'hA5A5_A5A5, 1, STAT_OK,      32'h0,         1, 2);
        add_row(CMD_CONTAINS,    32'hFFFF_FFFF, 32'h0,         1, STAT_OK,      32'h0,         1, 2);
        add_row(CMD_REMOVE,      32'hFFFF_FFFF, 32'h0,         1, STAT_OK,      32'h0,         1, 1);
        add_row(CMD_REMOVE,      32'hFFFF_FFFF, 32'h0,         1, STAT_UNKNOWN, 32'h0,         0, 1);
        add_row(CMD_CONTAINS,    32'hFFFF_FFFF, 32'h0,         1, STAT_OK,      32'h0,         0, 1);
        add_row(CMD_RESERVED_LO, 32'h0000_0000, 32'h0,         1, STAT_OK,      32'h0,         0, 1);
        add_row(CMD_RESERVED_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, STAT_OK,      32'h0,         0, 1);
        add_row(CMD_PUT,         32'h8000_0001, 32'h5A5A_5A5A, 0, STAT_OK,      32'h0,         0, 0);
        add_row(CMD_GET,         32'h0000_0000, 32'h0,         0, STAT_OK,      32'h0,         0, 0);
        add_row(CMD_REMOVE,      32'h0000_0000, 32'h0,         0, STAT_OK,      32'h0,         0, 0);
        add_row(CMD_GET,         32'h8000_0001, 32'h0,         0, STAT_OK,      32'h0,         0, 0);
        add_row(CMD_CLEAR,       32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, STAT_OK,      32'h0,         0, 0);
        add_row(CMD_GET,         32'h8000_0001, 32'h0,         1, STAT_EMPTY,   32'h0,         0, 0);
        add_row(CMD_CLEAR,       32'h0000_0000, 32'h0,         1, STAT_OK,      32'h0,         0, 0);

        // reset held low from time zero, released on a rising edge
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // phase one: sender idles 35%, receiver 73%
        tx_idle_pct = 35;
        rx_idle_pct = 73;
        foreach (directed_rows[i])
            send_command(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].rsp);
        // sender hold-off until every result is back
        wait_results_drained();
        run_random(RANDOM_PER_PHASE);

        // phase two: the other way round
        wait_results_drained();
        tx_idle_pct = 73;
        rx_idle_pct = 35;
        run_random(RANDOM_PER_PHASE);

        // phase three: full rate on both sides
        wait_results_drained();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(RANDOM_PER_PHASE);
        cmd_valid <= 1'b0;

        // drain, then give the block time to show any stray result
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (pending_responses.size() != 0)
            report_mismatch("results never returned", 64'(pending_responses.size()), 64'd0);

        if (error_count == 0)
            $display("PASS key_value_table_unit");
        else
            $display("FAIL key_value_table_unit");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/kvt_pkg.sv
rtl/kvt_datapath.sv
rtl/kvt_controller.sv
rtl/key_value_table_unit.sv
tb/sv/tb_top.sv
